>>> rtl/ksfsc_pkg.sv
// ----------------------------------------------------------------------------
// ksfsc_pkg
// Shared types and constants of the k-th free slot select-and-clear block.
// ----------------------------------------------------------------------------
package ksfsc_pkg;

	localparam int DEF_MAX_SLOTS = 1024;
	localparam int CFG_W         = 11;
	localparam int CVAL_W        = 10;
	localparam int POS_W         = 11;
	localparam int EPOCH_W       = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_LOAD,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic load;
		logic walk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic bad;
		logic leaf;
		logic sweep_last;
	} sts_t;

endpackage

>>> rtl/kth_free_slot_select_clear_core.sv
// ----------------------------------------------------------------------------
// kth_free_slot_select_clear_core
// Order-statistic tree: picks the (remaining - count)-th free slot, clears it
// and returns its 1-based position.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  config   | cfg_we             | cfg_wdata (slots_in_use)
//  input    | in_valid/in_ready  | start_req, count_value
//  output   | out_valid/out_ready| position, error
//
//  An item passes through accept, count check, a walk step per tree level
//  (the single read port of the tree RAM reads one node per step) and
//  hand-off; an error item skips the walk.
//  After reset, a clearing sweep over all 2*2^clog2(MAX_SLOTS) entries of
//  the tree RAM (2048) runs with in_ready low. Every 64th refill repeats it.
//  A new transaction is accepted while the previous result waits in the
//  output register; a stalled output holds the walk only at hand-off.
// ----------------------------------------------------------------------------
module kth_free_slot_select_clear_core
	import ksfsc_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              start_req,
	input  logic [CVAL_W-1:0] count_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  position,
	output logic              error
);

	cmd_t cmd;
	sts_t sts;

	ksfsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ksfsc_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start_req   (start_req),
		.count_value (count_value),
		.cmd         (cmd),
		.sts         (sts),
		.position    (position),
		.error       (error)
	);

endmodule

>>> rtl/ksfsc_ram.sv
// ----------------------------------------------------------------------------
// ksfsc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ksfsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ksfsc_ctrl.sv
// ----------------------------------------------------------------------------
// ksfsc_ctrl
// Controller: sequences reset sweep, refill sweep, count check, tree walk and
// result hand-off.
// ----------------------------------------------------------------------------
module ksfsc_ctrl
	import ksfsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = sts.wrap ? ST_SWEEP : ST_LOAD;
			end
			ST_SWEEP: begin
				if (sts.sweep_last) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				state_nxt = sts.bad ? ST_DONE : ST_WALK;
			end
			ST_WALK: begin
				if (sts.leaf) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_INIT;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_INIT:  cmd.sweep = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SWEEP: cmd.sweep = 1'b1;
			ST_LOAD:  cmd.load  = 1'b1;
			ST_WALK:  cmd.walk  = 1'b1;
			ST_DONE:  cmd.out_load = !out_valid_q || out_ready;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/ksfsc_dp.sv
// ----------------------------------------------------------------------------
// ksfsc_dp
// Datapath: taken-count tree in RAM tagged by refill epoch, walk registers,
// free-slot count and output register.
// ----------------------------------------------------------------------------
module ksfsc_dp
	import ksfsc_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              start_req,
	input  logic [CVAL_W-1:0] count_value,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [POS_W-1:0]  position,
	output logic              error
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int NODE_W = IDX_W + 1;
	localparam int DEPTH  = 2 ** NODE_W;
	localparam int MEM_W  = EPOCH_W + CNT_W;
	localparam int RST_N  = (int'(CFG_RESET) > MAX_SLOTS) ? MAX_SLOTS : int'(CFG_RESET);

	logic [CFG_W-1:0]   cfg_q;
	logic [CNT_W-1:0]   span_q;
	logic [CNT_W-1:0]   remaining_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CVAL_W-1:0]  count_q;
	logic               err_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   free_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [NODE_W-1:0]  node_q;
	logic [NODE_W-1:0]  sweep_q;
	logic [POS_W-1:0]   position_q;
	logic               error_q;

	logic [CNT_W-1:0]   fill_n;
	logic [IDX_W-1:0]   mid;
	logic [CNT_W-1:0]   size_left;
	logic [CNT_W-1:0]   size_right;
	logic [MEM_W-1:0]   rd_data;
	logic               rd_hit;
	logic [CNT_W-1:0]   left_free;
	logic               go_right;
	logic [NODE_W-1:0]  child_node;
	logic [CNT_W-1:0]   child_free;
	logic [CNT_W-1:0]   child_size;
	logic               ram_we;
	logic [NODE_W-1:0]  ram_waddr;
	logic [MEM_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [NODE_W-1:0]  ram_raddr;

	assign fill_n = (32'(cfg_q) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_q);

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign size_left  = CNT_W'(mid - lo_q) + CNT_W'(1);
	assign size_right = CNT_W'(hi_q - mid);
	assign rd_hit     = (rd_data[MEM_W-1 -: EPOCH_W] == epoch_q);
	assign left_free  = rd_hit ? (size_left - rd_data[CNT_W-1:0]) : size_left;
	assign go_right   = (left_free < k_q);
	assign child_node = {node_q[NODE_W-2:0], go_right};
	assign child_free = go_right ? (free_q - left_free) : left_free;
	assign child_size = go_right ? size_right : size_left;

	assign sts.wrap       = start_req && (&epoch_q);
	assign sts.bad        = (32'(count_q) >= 32'(remaining_q)) || (span_q == '0);
	assign sts.leaf       = (lo_q == hi_q);
	assign sts.sweep_last = (&sweep_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = child_node;
		ram_wdata = {epoch_q, child_size - child_free + CNT_W'(1)};
		ram_re    = 1'b0;
		ram_raddr = {child_node[NODE_W-2:0], 1'b0};
		priority if (cmd.sweep) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end else if (cmd.load) begin
			ram_re    = 1'b1;
			ram_raddr = NODE_W'(2);
		end else if (cmd.walk && !sts.leaf) begin
			ram_we = 1'b1;
			ram_re = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
	end

	ksfsc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (DEPTH)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_RESET;
			span_q      <= CNT_W'(RST_N);
			remaining_q <= CNT_W'(RST_N);
			epoch_q     <= '0;
			sweep_q     <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_q + NODE_W'(1);
			end
			if (cmd.accept && start_req) begin
				span_q      <= fill_n;
				remaining_q <= fill_n;
				epoch_q     <= epoch_q + EPOCH_W'(1);
			end else if (cmd.load && !sts.bad) begin
				remaining_q <= remaining_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			count_q <= count_value;
		end
		if (cmd.load) begin
			err_q  <= sts.bad;
			k_q    <= remaining_q - CNT_W'(count_q);
			free_q <= remaining_q;
			lo_q   <= '0;
			hi_q   <= IDX_W'(span_q - CNT_W'(1));
			node_q <= NODE_W'(1);
		end else if (cmd.walk && !sts.leaf) begin
			node_q <= child_node;
			free_q <= child_free;
			if (go_right) begin
				k_q  <= k_q - left_free;
				lo_q <= mid + IDX_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.out_load) begin
			position_q <= err_q ? '0 : POS_W'(32'(lo_q) + 32'd1);
			error_q    <= err_q;
		end
	end

	assign position = position_q;
	assign error    = error_q;

endmodule

>>> bench/ksfsc_slot_checker.sv
// ----------------------------------------------------------------------------
// ksfsc_slot_checker
// Watches the configuration, input and output channels of the k-th free slot
// select-and-clear core. A free-slot map, refilled and cleared as the core
// does, gives the position or error expected for every accepted transaction.
// Results are compared in order, field by field, and mismatches are counted.
// ----------------------------------------------------------------------------
module ksfsc_slot_checker
	import ksfsc_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              start_req,
	input  logic [CVAL_W-1:0] count_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [POS_W-1:0]  position,
	input  logic              error,
	output int                mismatches,
	output int                outstanding
);

	typedef struct {
		logic [POS_W-1:0] position;
		logic             error;
	} pick_t;

	pick_t            expected_picks[$];
	bit               slot_free[MAX_SLOTS];
	int               free_left;
	int               tree_span;
	logic [CFG_W-1:0] slots_reg;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void queue_pick(input pick_t p);
		expected_picks.insert(expected_picks.size(), p);
	endfunction

	function automatic void refill_slots();
		int n;
		n = (int'(slots_reg) > MAX_SLOTS) ? MAX_SLOTS : int'(slots_reg);
		for (int i = 0; i < MAX_SLOTS; i++)
			slot_free[i] = (i < n);
		tree_span = n;
		free_left = n;
	endfunction

	// take the (free_left - c)-th free slot from the left and clear it
	function automatic pick_t take_kth_free(input logic refill,
			input logic [CVAL_W-1:0] c);
		pick_t r;
		int    k;
		int    i;
		if (refill)
			refill_slots();
		r.position = '0;
		r.error    = 1'b1;
		if (int'(c) >= free_left)
			return r;
		k = free_left - int'(c);
		for (i = 0; i < tree_span; i++) begin
			if (slot_free[i]) begin
				k--;
				if (k == 0)
					break;
			end
		end
		slot_free[i] = 1'b0;
		free_left--;
		r.position = POS_W'(i + 1);
		r.error    = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		pick_t want;
		if (!arst_n) begin
			expected_picks.delete();
			slots_reg = CFG_RESET;
			refill_slots();
		end else begin
			if (cfg_we)
				slots_reg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_picks.size() == 0) begin
					report($sformatf("unexpected result position %0d error %0b",
						position, error));
				end else begin
					want = expected_picks.pop_front();
					if (position !== want.position)
						report($sformatf("position %0d, expected %0d",
							position, want.position));
					if (error !== want.error)
						report($sformatf("error %0b, expected %0b", error, want.error));
				end
			end
			if (in_valid && in_ready)
				queue_pick(take_kth_free(start_req, count_value));
		end
		outstanding = expected_picks.size();
	end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the k-th free slot select-and-clear core: a directed pass over
// field extremes, empty and zero-sized stores, oversized and mid-run register
// writes, then random permutation sequences with noise under four phases of
// input idling and output stalls. Checking is done by ksfsc_slot_checker.
// ----------------------------------------------------------------------------
module tb;
	import ksfsc_pkg::*;

	localparam int SIM_CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS     = 240;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              start_req;
	logic [CVAL_W-1:0] count_value;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [POS_W-1:0]  position;
	logic              error;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int cfg_now = int'(CFG_RESET);
	int slots_left;

	kth_free_slot_select_clear_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_req   (start_req),
		.count_value (count_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.error       (error)
	);

	ksfsc_slot_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_req   (start_req),
		.count_value (count_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.error       (error),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > SIM_CYCLE_LIMIT) begin
			$display("** kth_free_slot_select_clear_core: FAILED **");
			$finish;
		end
	end

	function automatic int refill_size(input int v);
		return (v > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : v;
	endfunction

	task automatic send_item(input logic st, input int c);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		start_req   <= st;
		count_value <= CVAL_W'(c);
		do @(posedge clk); while (!in_ready);
		if (st)
			slots_left = refill_size(cfg_now);
		if (c < slots_left)
			slots_left--;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_slots(input int v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_now = v;
	endtask

	task automatic run_sequence();
		int r;
		int v;
		int len;
		int fresh;
		logic st;
		if ($urandom_range(0, 99) < 40) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				v = $urandom_range(1, 40);
			else if (r < 78)
				v = $urandom_range(41, 1023);
			else if (r < 88)
				v = $urandom_range(1024, 2047);
			else if (r < 94)
				v = 0;
			else
				v = 1;
			write_slots(v);
		end
		st = ($urandom_range(0, 9) != 0);
		fresh = st ? refill_size(cfg_now) : slots_left;
		len = (fresh <= 40) ? fresh + $urandom_range(0, 2) : $urandom_range(20, 60);
		if (len == 0)
			len = 1;
		for (int i = 0; i < len; i++) begin
			if (i > 0)
				st = ($urandom_range(0, 99) < 3);
			if (st)
				fresh = refill_size(cfg_now);
			else
				fresh = slots_left;
			if (fresh > 0 && $urandom_range(0, 99) < 85)
				send_item(st, $urandom_range(0, fresh - 1));
			else
				send_item(st, $urandom_range(0, 1023));
		end
	endtask

	initial begin
		int done;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		start_req   = 1'b0;
		count_value = '0;
		slots_left  = DEF_MAX_SLOTS;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes at the reset size
		send_item(1'b0, 0);
		send_item(1'b0, 1022);
		send_item(1'b0, 1023);
		send_item(1'b1, 1023);
		send_item(1'b0, 512);
		// single slot, then empty store
		write_slots(1);
		send_item(1'b1, 0);
		send_item(1'b0, 0);
		send_item(1'b0, 1023);
		// zero-sized refill
		write_slots(0);
		send_item(1'b1, 0);
		send_item(1'b0, 5);
		// oversized register saturates
		write_slots(2047);
		send_item(1'b1, 1023);
		send_item(1'b1, 0);
		// register change without refill keeps the old span
		write_slots(3);
		send_item(1'b1, 2);
		write_slots(5);
		send_item(1'b0, 0);
		send_item(1'b0, 0);
		send_item(1'b0, 0);
		send_item(1'b1, 4);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 76; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 76; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			done = 0;
			while (done < PHASE_ITEMS) begin
				run_sequence();
				done = done + 1 + (refill_size(cfg_now) <= 40 ? refill_size(cfg_now) : 40);
			end
		end

		wait_drained();
		repeat (30) @(negedge clk);
		if (mismatches == 0)
			$display("** kth_free_slot_select_clear_core: PASSED **");
		else
			$display("** kth_free_slot_select_clear_core: FAILED **");
		$finish;
	end

endmodule
